FILE: hdl/lras_pkg.sv
// Shared widths, register indexes, types and helper functions of the line rasterizer.
package lras_pkg;

    localparam int X_W         = 9;
    localparam int Y_W         = 8;
    localparam int COLOUR_W    = 16;
    localparam int ADDR_W      = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Byte offset of one frame buffer row is 1 << ROW_SHIFT.
    localparam int ROW_SHIFT = 10;

    // The scaled product 10*db*t has a magnitude below 2^22; the divisor is a 9-bit span.
    localparam int DIV_NUM_W = 22;
    localparam int DIV_DEN_W = 9;
    localparam int ACC_W     = 24;
    localparam int HALF_STEP = 5;

    // Division by ten as a multiply by ceil(2^26 / 10) and a shift; exact below 2^26 / 6.
    localparam int                 RECIP_SHIFT = 26;
    localparam int                 RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_TEN   = 23'd6710887;

    localparam logic [CFG_INDEX_W-1:0] REG_START_X     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Y     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_END_X       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_Y       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PEN_COLOUR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_BASE = 3'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } lras_div_stat_t;

    typedef struct packed {
        logic [X_W-1:0] a0;
        logic [X_W-1:0] a1;
        logic [X_W-1:0] b0;
        logic [X_W-1:0] b1;
    } axes_t;

    function automatic logic steep_slope(input logic [X_W-1:0] sx, input logic [Y_W-1:0] sy,
                                         input logic [X_W-1:0] ex, input logic [Y_W-1:0] ey);
        logic [X_W:0]   dx;
        logic [Y_W:0]   dy;
        logic [X_W-1:0] adx;
        logic [Y_W-1:0] ady;
        dx  = {1'b0, ex} - {1'b0, sx};
        dy  = {1'b0, ey} - {1'b0, sy};
        adx = dx[X_W] ? X_W'(~dx + 1'b1) : dx[X_W-1:0];
        ady = dy[Y_W] ? Y_W'(~dy + 1'b1) : dy[Y_W-1:0];
        return {1'b0, ady} > adx;
    endfunction

    // Picks the major axis and orders the endpoints so the major coordinate rises.
    function automatic axes_t order_axes(input logic steep,
                                         input logic [X_W-1:0] sx, input logic [Y_W-1:0] sy,
                                         input logic [X_W-1:0] ex, input logic [Y_W-1:0] ey);
        logic [X_W-1:0] pa;
        logic [X_W-1:0] pb;
        logic [X_W-1:0] qa;
        logic [X_W-1:0] qb;
        axes_t          ax;
        pa = steep ? {1'b0, sy} : sx;
        pb = steep ? sx : {1'b0, sy};
        qa = steep ? {1'b0, ey} : ex;
        qb = steep ? ex : {1'b0, ey};
        if (pa > qa)
        begin
            ax.a0 = qa;
            ax.b0 = qb;
            ax.a1 = pa;
            ax.b1 = pb;
        end
        else
        begin
            ax.a0 = pa;
            ax.b0 = pb;
            ax.a1 = qa;
            ax.b1 = qb;
        end
        return ax;
    endfunction

endpackage

FILE: hdl/lras_div.sv
// Iterative restoring divider, one quotient bit per clock cycle.
module lras_div
    import lras_pkg::*;
#(
    parameter int NUM_WIDTH = DIV_NUM_W,
    parameter int DEN_WIDTH = DIV_DEN_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] dividend,
    input  logic [DEN_WIDTH-1:0] divisor,
    output logic [NUM_WIDTH-1:0] quotient,
    output lras_div_stat_t       stat
);

    localparam int CNT_W = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] quo_reg;
    logic [NUM_WIDTH-1:0] quo_next;
    logic [DEN_WIDTH-1:0] rem_reg;
    logic [DEN_WIDTH-1:0] rem_next;
    logic [DEN_WIDTH-1:0] den_reg;
    logic [DEN_WIDTH:0]   rem_shift;
    logic [DEN_WIDTH:0]   rem_diff;
    logic                 rem_ge;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    assign rem_shift = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign rem_next  = rem_ge ? rem_diff[DEN_WIDTH-1:0] : rem_shift[DEN_WIDTH-1:0];
    assign quo_next  = {quo_reg[NUM_WIDTH-2:0], rem_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(NUM_WIDTH);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");

    a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_busy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with no bits left");
`endif

endmodule

FILE: hdl/line_rasterizer_top.sv
// Top level of the line rasterizer: configuration registers, sequencer and pixel output.
//
// Software writes the endpoints, the pen colour and the frame buffer base through the
// configuration port while no pixel is pending. A transaction with restart = 1 starts the
// line at its first pixel; each transaction with restart = 0 produces the next pixel, and one
// that arrives when no line is active produces nothing and leaves the sequencer idle. A pixel
// carries its x, its y, its byte address base + (y << 10) + 2*x, the colour and a last flag.
// After acceptance a pixel passes the multiply, divide, round, scale and done states; the
// divider works out 10*db*t / da one quotient bit at a time, and the result register lets
// the next transaction start while a pixel still waits downstream.
module line_rasterizer_top
    import lras_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   restart_valid,
    output logic                   restart_stall,
    input  logic                   restart,
    output logic                   pixel_valid,
    input  logic                   pixel_stall,
    output logic [X_W-1:0]         pixel_x,
    output logic [Y_W-1:0]         pixel_y,
    output logic [ADDR_W-1:0]      pixel_address,
    output logic [COLOUR_W-1:0]    pixel_colour,
    output logic                   last_pixel
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam int PROD_W   = 2 * (X_W + 1);
    localparam int SCALED_W = DIV_NUM_W + RECIP_W;

    logic [X_W-1:0]      start_x_reg;
    logic [Y_W-1:0]      start_y_reg;
    logic [X_W-1:0]      end_x_reg;
    logic [Y_W-1:0]      end_y_reg;
    logic [COLOUR_W-1:0] pen_colour_reg;
    logic [ADDR_W-1:0]   buffer_base_reg;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic                steep_reg;
    logic                line_active_reg;
    logic [X_W-1:0]      major_pos_reg;
    logic                div_start_reg;
    logic                pixel_valid_reg;

    logic                num_neg_reg;
    logic [DIV_NUM_W-1:0] num_mag_reg;
    logic                v_neg_reg;
    logic [DIV_NUM_W-1:0] v_mag_reg;
    logic [X_W-1:0]      r_low_reg;
    logic [X_W-1:0]      r_low_next;

    logic [X_W-1:0]      pixel_x_reg;
    logic [Y_W-1:0]      pixel_y_reg;
    logic [ADDR_W-1:0]   pixel_address_reg;
    logic [COLOUR_W-1:0] pixel_colour_reg;
    logic                last_pixel_reg;

    logic                accept;
    logic                out_load;
    logic                steep_now;
    axes_t               ax_start;
    axes_t               ax;
    logic [X_W-1:0]      da;
    logic                da_zero;
    logic signed [X_W:0] db;
    logic signed [X_W:0] t;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]    prod_ext;
    logic [ACC_W-1:0]    num;
    logic [ACC_W-1:0]    num_abs;
    logic [DIV_NUM_W-1:0] quotient;
    lras_div_stat_t      div_stat;
    logic [ACC_W-1:0]    q_signed;
    logic [ACC_W-1:0]    v;
    logic [ACC_W-1:0]    v_abs;
    logic [SCALED_W-1:0] scaled;
    logic [X_W-1:0]      r_mag;
    logic [X_W-1:0]      minor;
    logic [X_W-1:0]      px;
    logic [Y_W-1:0]      py;
    logic [ADDR_W-1:0]   addr;
    logic                last_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
            pen_colour_reg  <= '0;
            buffer_base_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_X:     start_x_reg     <= cfg_data[X_W-1:0];
                REG_START_Y:     start_y_reg     <= cfg_data[Y_W-1:0];
                REG_END_X:       end_x_reg       <= cfg_data[X_W-1:0];
                REG_END_Y:       end_y_reg       <= cfg_data[Y_W-1:0];
                REG_PEN_COLOUR:  pen_colour_reg  <= cfg_data[COLOUR_W-1:0];
                REG_BUFFER_BASE: buffer_base_reg <= cfg_data[ADDR_W-1:0];
                default:         ;
            endcase
        end
    end

    assign restart_stall = (state_reg != S_IDLE);
    assign accept        = restart_valid && !restart_stall;
    assign out_load      = (state_reg == S_DONE) && (!pixel_valid_reg || !pixel_stall);

    // Axes for a fresh start use the slope seen now; a running line keeps its latched slope.
    assign steep_now = steep_slope(start_x_reg, start_y_reg, end_x_reg, end_y_reg);
    assign ax_start  = order_axes(steep_now, start_x_reg, start_y_reg, end_x_reg, end_y_reg);
    assign ax        = order_axes(steep_reg, start_x_reg, start_y_reg, end_x_reg, end_y_reg);

    assign da       = ax.a1 - ax.a0;
    assign da_zero  = (da == '0);
    assign db       = signed'({1'b0, ax.b1}) - signed'({1'b0, ax.b0});
    assign t        = signed'({1'b0, major_pos_reg}) - signed'({1'b0, ax.a0});
    assign prod     = db * t;
    assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    assign num      = (prod_ext << 3) + (prod_ext << 1);
    assign num_abs  = num[ACC_W-1] ? (~num + 1'b1) : num;

    // The divider truncates magnitudes, so the sign is put back afterwards.
    assign q_signed = num_neg_reg ? (~{{(ACC_W - DIV_NUM_W){1'b0}}, quotient} + 1'b1)
                                  : {{(ACC_W - DIV_NUM_W){1'b0}}, quotient};
    assign v        = q_signed + ACC_W'(HALF_STEP);
    assign v_abs    = v[ACC_W-1] ? (~v + 1'b1) : v;

    assign scaled     = v_mag_reg * RECIP_TEN;
    assign r_mag      = scaled[RECIP_SHIFT +: X_W];
    assign r_low_next = v_neg_reg ? (~r_mag + 1'b1) : r_mag;

    assign minor    = da_zero ? ax.b0 : (ax.b0 + r_low_reg);
    assign px       = steep_reg ? minor : major_pos_reg;
    assign py       = steep_reg ? major_pos_reg[Y_W-1:0] : minor[Y_W-1:0];
    assign addr     = buffer_base_reg + ({{(ADDR_W - Y_W){1'b0}}, py} << ROW_SHIFT)
                      + {{(ADDR_W - X_W - 1){1'b0}}, px, 1'b0};
    assign last_now = (major_pos_reg >= ax.a1);

    lras_div #(
        .NUM_WIDTH (DIV_NUM_W),
        .DEN_WIDTH (DIV_DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (num_mag_reg),
        .divisor  (da),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (restart || line_active_reg))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND: state_next = S_SCALE;
            S_SCALE: state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            steep_reg       <= 1'b0;
            line_active_reg <= 1'b0;
            major_pos_reg   <= '0;
            div_start_reg   <= 1'b0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= (state_reg == S_MUL);
            if (accept && restart)
            begin
                steep_reg       <= steep_now;
                major_pos_reg   <= ax_start.a0;
                line_active_reg <= 1'b1;
            end
            else if (out_load)
            begin
                major_pos_reg <= major_pos_reg + 1'b1;
                if (last_now)
                begin
                    line_active_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                pixel_valid_reg <= 1'b1;
            end
            else if (!pixel_stall)
            begin
                pixel_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            num_neg_reg <= num[ACC_W-1];
            num_mag_reg <= num_abs[DIV_NUM_W-1:0];
        end
        if (state_reg == S_ROUND)
        begin
            v_neg_reg <= v[ACC_W-1];
            v_mag_reg <= v_abs[DIV_NUM_W-1:0];
        end
        if (state_reg == S_SCALE)
        begin
            r_low_reg <= r_low_next;
        end
        if (out_load)
        begin
            pixel_x_reg       <= px;
            pixel_y_reg       <= py;
            pixel_address_reg <= addr;
            pixel_colour_reg  <= pen_colour_reg;
            last_pixel_reg    <= last_now;
        end
    end

    assign pixel_valid   = pixel_valid_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign pixel_address = pixel_address_reg;
    assign pixel_colour  = pixel_colour_reg;
    assign last_pixel    = last_pixel_reg;

`ifndef SYNTH
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider result arrived outside the divide state");

    a_work_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> line_active_reg)
        else $error("pixel computed with no active line");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_now) |=> !line_active_reg)
        else $error("line still active after its last pixel");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("pixel presented without a finished computation");
`endif

endmodule
